/* design/fsf_pkg.sv */
// Shared types and constants for the sparse tensor fiber builder.
// No dependencies; every other design file imports this package.
package fsf_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int NUM_COORDS    = 8;
	localparam int COORD_W       = 32;
	localparam int SEL_W         = 3;
	localparam int LEVEL_W       = 3;
	localparam int PTR_W         = 32;
	localparam int NUM_MODES_W   = 4;
	localparam int MODE_ORDER_W  = 24;
	localparam int CFG_DATA_W    = 24;
	localparam int S_TDATA_W     = NUM_COORDS * COORD_W;
	localparam int M_PAYLOAD_W   = LEVEL_W + COORD_W + PTR_W;
	localparam int M_TDATA_W     = ((M_PAYLOAD_W + 7) / 8) * 8;

	// Defaults for the top-level parameters.
	localparam int MAX_MODES_DEF  = 8;
	localparam int INDEX_BITS_DEF = 32;

	// Register reset values; the mode order reset is the identity order.
	localparam logic [NUM_MODES_W-1:0]  NUM_MODES_RST  = 4'd3;
	localparam logic [MODE_ORDER_W-1:0] MODE_ORDER_RST = 24'd16434824;

	// Configuration register indexes.
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_NUM_MODES  = 1'b0;
	localparam cfg_idx_t CFG_MODE_ORDER = 1'b1;

	// Per-lane control for one accepted nonzero.
	typedef struct packed {
		logic upd;      // a transaction is accepted this cycle
		logic start;    // a new fiber starts at this level
		logic leaf;     // this lane is the leaf level, counting nonzeros
		logic wr_prev;  // this level is in use, keep its coordinate
		logic clear;    // final nonzero, return counters to reset
	} lane_ctrl_t;

endpackage

/* design/fsf_lane.sv */
// One tree level of the fiber builder: coordinate select, compare with the
// previous nonzero, and the saturating fiber counter. Depends on fsf_pkg.
module fsf_lane
	import fsf_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_W-1:0]    coords [NUM_COORDS],
	input  logic [SEL_W-1:0]      sel,
	input  lane_ctrl_t            ctrl,
	output logic [INDEX_BITS-1:0] lv,
	output logic                  differ,
	output logic [INDEX_BITS-1:0] count,
	output logic [INDEX_BITS-1:0] count_nx
);

	logic [INDEX_BITS-1:0] prev_q;
	logic [INDEX_BITS-1:0] count_q;

	// Pick the tensor mode that feeds this level and compare it.
	assign lv     = INDEX_BITS'(coords[sel]);
	assign differ = (lv != prev_q);

	// Counter value after this nonzero, saturating at all ones.
	always_comb begin
		count_nx = count_q;
		if (ctrl.start || ctrl.leaf) begin
			if (count_q != '1) begin
				count_nx = count_q + 1'b1;
			end
		end
	end

	assign count = count_q;

	// Level state, cleared after the final nonzero of a tensor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			count_q <= '0;
		end else if (ctrl.upd) begin
			if (ctrl.clear) begin
				prev_q  <= '0;
				count_q <= '0;
			end else begin
				count_q <= count_nx;
				if (ctrl.wr_prev) begin
					prev_q <= lv;
				end
			end
		end
	end

endmodule

/* design/fsf_emit.sv */
// Result sequencer: holds one nonzero's pending fiber and end entries and
// sends them one per cycle while the receiver is ready, through a registered output. Depends on fsf_pkg.
module fsf_emit
	import fsf_pkg::*;
#(
	parameter int MAX_MODES  = MAX_MODES_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [MAX_MODES-1:0]  fiber_mask,
	input  logic [MAX_MODES-1:0]  end_mask,
	input  logic [INDEX_BITS-1:0] lv [MAX_MODES],
	input  logic [INDEX_BITS-1:0] fchild [MAX_MODES],
	input  logic [INDEX_BITS-1:0] echild [MAX_MODES],
	output logic                  ready,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // level, fiber_index, child_start, zero fill
	output logic [0:0]            m_axis_tuser,  // is_end
	output logic                  m_axis_tlast   // run_last
);

	localparam int LW = $clog2(MAX_MODES);

	logic [MAX_MODES-1:0]  pend_fiber_s1;
	logic [MAX_MODES-1:0]  pend_end_s1;
	logic [INDEX_BITS-1:0] lv_s1 [MAX_MODES];
	logic [INDEX_BITS-1:0] fchild_s1 [MAX_MODES];
	logic [INDEX_BITS-1:0] echild_s1 [MAX_MODES];

	logic                  busy;
	logic                  sel_end;
	logic [MAX_MODES-1:0]  pick;
	logic [MAX_MODES-1:0]  pick_left;
	logic [LW-1:0]         idx;
	logic                  rest_empty;
	logic                  move;

	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [COORD_W-1:0]    fiber_index_q;
	logic [PTR_W-1:0]      child_start_q;
	logic                  is_end_q;
	logic                  run_last_q;

	// Fiber entries go out first, lowest level first, then end entries.
	always_comb begin
		busy    = (|pend_fiber_s1) || (|pend_end_s1);
		sel_end = (pend_fiber_s1 == '0);
		pick    = sel_end ? pend_end_s1 : pend_fiber_s1;
		idx     = '0;
		for (int i = MAX_MODES - 1; i >= 0; i--) begin
			if (pick[i]) begin
				idx = LW'(i);
			end
		end
		pick_left  = pick & ~(MAX_MODES'(1) << idx);
		rest_empty = (pick_left == '0) && (sel_end || (pend_end_s1 == '0));
		move       = busy && (!out_valid_q || m_axis_tready);
		ready      = !busy || (move && rest_empty);
	end

	// Holding stage for the entries of one nonzero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_fiber_s1 <= '0;
			pend_end_s1   <= '0;
		end else if (load) begin
			pend_fiber_s1 <= fiber_mask;
			pend_end_s1   <= end_mask;
		end else if (move) begin
			if (sel_end) begin
				pend_end_s1 <= pick_left;
			end else begin
				pend_fiber_s1 <= pick_left;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lv_s1     <= lv;
			fchild_s1 <= fchild;
			echild_s1 <= echild;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			level_q       <= LEVEL_W'(idx);
			fiber_index_q <= sel_end ? '0 : COORD_W'(lv_s1[idx]);
			child_start_q <= sel_end ? PTR_W'(echild_s1[idx]) : PTR_W'(fchild_s1[idx]);
			is_end_q      <= sel_end;
			run_last_q    <= rest_empty;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({child_start_q, fiber_index_q, level_q});
	assign m_axis_tuser  = is_end_q;
	assign m_axis_tlast  = run_last_q;

	// A new nonzero never replaces one whose entries are still pending.
	a_load_when_ready : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("fsf_emit: load while entries pending");

	// Only nonzeros with at least one entry are loaded.
	a_load_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((fiber_mask != '0) || (end_mask != '0)))
		else $error("fsf_emit: empty load");

	// After the last entry leaves with no new load, the stage is empty.
	a_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(move && rest_empty && !load) |=> !busy)
		else $error("fsf_emit: entries left after last result");

	// The last level, the leaf when all MAX_MODES levels are used, never produces an entry.
	a_no_leaf_entry : assert property (@(posedge clk) disable iff (!arst_n)
		!pend_fiber_s1[MAX_MODES-1] && !pend_end_s1[MAX_MODES-1])
		else $error("fsf_emit: entry pending at leaf level");

endmodule

/* design/sparse_tensor_fiber_builder.sv */
// Sparse tensor fiber builder top level: configuration registers, per-level
// lanes, level merge and result sequencer. Depends on fsf_pkg, fsf_lane, fsf_emit.
//
// Sorted nonzeros enter one per transaction; each level's coordinate is chosen by
// mode_order and compared with the previous nonzero in its own lane, and the
// merge finds the first differing level. Each new fiber yields one result
// (level, coordinate, start of its child); the final nonzero also yields one
// end pointer per non-leaf level and then returns all counters to zero. An
// item is accepted in the same cycle its state update is computed, so items
// with zero or one result stream at one per cycle while the receiver is ready.
// An item with more results holds the input until its last result enters the
// registered output, which takes one result per cycle; receiver stalls hold it
// further. An item's results pass through the holding stage and then the
// output register before they are presented.
module sparse_tensor_fiber_builder
	import fsf_pkg::*;
#(
	parameter int MAX_MODES  = MAX_MODES_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // coord_0 .. coord_7
	input  logic                  s_axis_tlast,  // final_nonzero
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // level, fiber_index, child_start, zero fill
	output logic [0:0]            m_axis_tuser,  // is_end
	output logic                  m_axis_tlast   // run_last
);

	logic [NUM_MODES_W-1:0]  num_modes_q;
	logic [MODE_ORDER_W-1:0] mode_order_q;
	logic                    have_prev_q;

	logic [COORD_W-1:0]    coords [NUM_COORDS];
	logic                  accept;
	logic [NUM_MODES_W-1:0] nm;
	logic [NUM_MODES_W-1:0] nl;
	logic [MAX_MODES-1:0]  differ;
	logic [MAX_MODES-1:0]  start;
	logic [MAX_MODES-1:0]  end_mask;
	lane_ctrl_t            ctrl [MAX_MODES];
	logic                  load;

	logic [INDEX_BITS-1:0] lv_w [MAX_MODES];
	logic [INDEX_BITS-1:0] cnt_w [MAX_MODES];
	logic [INDEX_BITS-1:0] cntnx_w [MAX_MODES];
	logic [INDEX_BITS-1:0] fchild [MAX_MODES];
	logic [INDEX_BITS-1:0] echild [MAX_MODES];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_modes_q  <= NUM_MODES_RST;
			mode_order_q <= MODE_ORDER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_MODES:  num_modes_q  <= cfg_data[NUM_MODES_W-1:0];
				CFG_MODE_ORDER: mode_order_q <= cfg_data[MODE_ORDER_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the coordinates of the input transaction.
	always_comb begin
		for (int k = 0; k < NUM_COORDS; k++) begin
			coords[k] = s_axis_tdata[k*COORD_W +: COORD_W];
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	// Level merge: clamp the level count, then find where new fibers start.
	always_comb begin
		logic any_diff;
		logic [NUM_MODES_W-1:0] lvl;
		if (num_modes_q < NUM_MODES_W'(2)) begin
			nm = NUM_MODES_W'(2);
		end else if (num_modes_q > NUM_MODES_W'(MAX_MODES)) begin
			nm = NUM_MODES_W'(MAX_MODES);
		end else begin
			nm = num_modes_q;
		end
		nl       = nm - 1'b1;
		any_diff = 1'b0;
		for (int l = 0; l < MAX_MODES; l++) begin
			lvl         = NUM_MODES_W'(l);
			any_diff    = any_diff || (differ[l] && (lvl < nl));
			start[l]    = (lvl < nl) && (!have_prev_q || any_diff);
			end_mask[l] = (lvl < nl) && s_axis_tlast;
			ctrl[l].upd     = accept;
			ctrl[l].start   = start[l];
			ctrl[l].leaf    = (lvl == nl);
			ctrl[l].wr_prev = (lvl < nm);
			ctrl[l].clear   = s_axis_tlast;
		end
		load = accept && ((start != '0) || s_axis_tlast);
	end

	// The first nonzero of a tensor starts fibers at every non-leaf level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= !s_axis_tlast;
		end
	end

	// One lane per tree level.
	for (genvar l = 0; l < MAX_MODES; l++) begin : g_lane
		fsf_lane #(
			.INDEX_BITS(INDEX_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.coords   (coords),
			.sel      (mode_order_q[SEL_W*l +: SEL_W]),
			.ctrl     (ctrl[l]),
			.lv       (lv_w[l]),
			.differ   (differ[l]),
			.count    (cnt_w[l]),
			.count_nx (cntnx_w[l])
		);

		// A fiber's child pointer is the count of the level below it.
		if (l < MAX_MODES - 1) begin : g_child
			assign fchild[l] = cnt_w[l+1];
			assign echild[l] = cntnx_w[l+1];
		end else begin : g_last
			assign fchild[l] = '0;
			assign echild[l] = '0;
		end
	end

	fsf_emit #(
		.MAX_MODES (MAX_MODES),
		.INDEX_BITS(INDEX_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.fiber_mask   (start),
		.end_mask     (end_mask),
		.lv           (lv_w),
		.fchild       (fchild),
		.echild       (echild),
		.ready        (s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

/* sim/sparse_tensor_fiber_builder_tb.sv */
// Self-checking testbench for the sparse tensor fiber builder: directed and random
// nonzero streams, checked against a fiber-building predictor. Depends on every design file.
module sparse_tensor_fiber_builder_tb;
	import fsf_pkg::*;

	// One result entry as it leaves the block.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [COORD_W-1:0] fiber_index;
		logic [PTR_W-1:0]   child_start;
		logic               is_end;
		logic               run_last;
	} fiber_entry_t;

	// One directed nonzero; coordinates 3 to 7 share c_rest.
	// n_typed below zero means the predictor supplies the expected entries.
	typedef struct {
		logic [COORD_W-1:0] c0, c1, c2, c_rest;
		logic               last;
		int                 n_typed;
	} nz_row_t;

	localparam int NUM_ROWS   = 14;
	localparam int NUM_TYPED  = 11;
	localparam int NUM_PHASES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_NUM_MODES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // coord_0 .. coord_7
	logic                  s_axis_tlast = 1'b0;  // final_nonzero
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;  // level, fiber_index, child_start, zero fill
	logic [0:0]            m_axis_tuser;  // is_end
	logic                  m_axis_tlast;  // run_last

	// Predictor state and its copy of the registers.
	logic [COORD_W-1:0] lvl_prev [NUM_COORDS];
	logic [PTR_W-1:0]   lvl_count [NUM_COORDS];
	bit                 seen_any;
	logic [NUM_MODES_W-1:0]  cfg_levels;
	logic [MODE_ORDER_W-1:0] cfg_order;

	fiber_entry_t step_entries [$];
	fiber_entry_t pending_entries [$];
	int           fail_count = 0;

	// Traffic shaping shared between the sender and the receiver.
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_req = 1'b0;

	logic [COORD_W-1:0] walk [NUM_COORDS];

	nz_row_t dir_rows [0:NUM_ROWS-1] = '{
		'{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 2},
		'{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 2},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 4},
		'{32'd5, 32'd7, 32'd9, 32'd0, 1'b0, 2},
		'{32'd5, 32'd7, 32'd10, 32'd0, 1'b0, 0},
		'{32'd5, 32'd7, 32'd10, 32'd0, 1'b0, 0},
		'{32'd5, 32'd8, 32'd0, 32'd0, 1'b0, 1},
		'{32'd6, 32'd0, 32'd0, 32'd0, 1'b0, -1},
		'{32'd3, 32'd1, 32'd1, 32'd0, 1'b0, -1},
		'{32'd3, 32'd1, 32'd1, 32'hA5A5A5A5, 1'b0, -1},
		'{32'd3, 32'd1, 32'd1, 32'hFFFFFFFF, 1'b1, -1},
		'{32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0, 1'b0, -1},
		'{32'd0, 32'hFFFFFFFF, 32'd0, 32'h5A5A5A5A, 1'b1, -1},
		'{32'd1, 32'd2, 32'd3, 32'd0, 1'b1, -1}
	};

	// Entries read straight off the first rows, in order.
	fiber_entry_t typed_tab [0:NUM_TYPED-1] = '{
		'{3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
		'{3'd1, 32'd0, 32'd0, 1'b0, 1'b1},
		'{3'd0, 32'd0, 32'd1, 1'b1, 1'b0},
		'{3'd1, 32'd0, 32'd2, 1'b1, 1'b1},
		'{3'd0, 32'hFFFFFFFF, 32'd0, 1'b0, 1'b0},
		'{3'd1, 32'hFFFFFFFF, 32'd0, 1'b0, 1'b0},
		'{3'd0, 32'd0, 32'd1, 1'b1, 1'b0},
		'{3'd1, 32'd0, 32'd1, 1'b1, 1'b1},
		'{3'd0, 32'd5, 32'd0, 1'b0, 1'b0},
		'{3'd1, 32'd7, 32'd0, 1'b0, 1'b1},
		'{3'd1, 32'd8, 32'd3, 1'b0, 1'b1}
	};

	// Phase settings: raw num_modes, mode order, and whether the order is drawn at random.
	logic [NUM_MODES_W-1:0]  phase_levels [NUM_PHASES] = '{4'd2, 4'd8, 4'd0, 4'd15,
		4'd5, 4'd1, 4'd9, 4'd4};
	logic [MODE_ORDER_W-1:0] phase_order [NUM_PHASES] = '{24'hFAC688, 24'hFAC688,
		24'hFFFFFF, 24'h000000, 24'h000000, 24'h053977, 24'h000000, 24'hFAC688};
	bit phase_rand_order [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 1, 1};

	sparse_tensor_fiber_builder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [PTR_W-1:0] sat_bump(input logic [PTR_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void clear_fiber_state();
		for (int k = 0; k < NUM_COORDS; k++) begin
			lvl_prev[k] = '0;
			lvl_count[k] = '0;
		end
		seen_any = 1'b0;
	endfunction

	// Works out the entries that one accepted nonzero produces and advances the state.
	function automatic void build_fibers(input logic [S_TDATA_W-1:0] data, input logic last);
		logic [COORD_W-1:0] lv [NUM_COORDS];
		fiber_entry_t e;
		int nm, nl, d, l, n, k;
		bit hit;
		step_entries.delete();
		nm = cfg_levels;
		if (nm < 2) nm = 2;
		if (nm > NUM_COORDS) nm = NUM_COORDS;
		nl = nm - 1;
		for (l = 0; l < nm; l++)
			lv[l] = data[COORD_W * cfg_order[SEL_W*l +: SEL_W] +: COORD_W];

		// The first differing non-leaf level opens new fibers down to the leaf.
		d = 0;
		if (seen_any) begin
			d = nl;
			hit = 1'b0;
			for (l = 0; l < nl; l++) begin
				if (!hit && lv[l] != lvl_prev[l]) begin
					d = l;
					hit = 1'b1;
				end
			end
		end
		n = (nl - d) + (last ? nl : 0);
		k = 0;
		for (l = d; l < nl; l++) begin
			e.level = 3'(l);
			e.fiber_index = lv[l];
			e.child_start = lvl_count[l + 1];
			e.is_end = 1'b0;
			e.run_last = (k == n - 1);
			step_entries.push_back(e);
			k++;
			lvl_count[l] = sat_bump(lvl_count[l]);
		end
		lvl_count[nl] = sat_bump(lvl_count[nl]);
		for (l = 0; l < nm; l++)
			lvl_prev[l] = lv[l];
		seen_any = 1'b1;

		// The final nonzero closes every non-leaf level and starts a fresh tensor.
		if (last) begin
			for (l = 0; l < nl; l++) begin
				e.level = 3'(l);
				e.fiber_index = '0;
				e.child_start = lvl_count[l + 1];
				e.is_end = 1'b1;
				e.run_last = (k == n - 1);
				step_entries.push_back(e);
				k++;
			end
			clear_fiber_state();
		end
	endfunction

	// Offers one nonzero and returns at the edge where the transaction is taken.
	task automatic offer_nonzero(input logic [S_TDATA_W-1:0] data, input logic last);
		int gap;
		bit took;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid = 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = data;
		s_axis_tlast = last;
		took = 1'b0;
		while (!took) begin
			#1 took = s_axis_tready;
			@(posedge clk);
			if (!took) @(negedge clk);
		end
	endtask

	// Stops offering and waits until every expected entry has come out and the block is quiet.
	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_NUM_MODES)
			cfg_levels = val[NUM_MODES_W-1:0];
		else if (idx == CFG_MODE_ORDER)
			cfg_order = val[MODE_ORDER_W-1:0];
	endtask

	// One configuration followed by a mostly sorted random stream of nonzeros.
	// With hold_off set, the receiver is held off while the stream keeps coming.
	task automatic run_phase(input logic [NUM_MODES_W-1:0] nm_raw,
			input logic [MODE_ORDER_W-1:0] order, input int items, input int pause_at,
			input bit hold_off);
		logic [S_TDATA_W-1:0] data;
		logic [31:0] junk;
		logic last;
		int nm_eff, lvl, r, i, k;
		settle_block();
		junk = $urandom;
		write_reg(CFG_NUM_MODES, {junk[CFG_DATA_W-NUM_MODES_W-1:0], nm_raw});
		write_reg(CFG_MODE_ORDER, order);
		if (hold_off)
			hold_req = 1'b1;
		nm_eff = nm_raw;
		if (nm_eff < 2) nm_eff = 2;
		if (nm_eff > NUM_COORDS) nm_eff = NUM_COORDS;
		for (i = 0; i < items; i++) begin
			if (i == pause_at)
				settle_block();
			r = $urandom_range(0, 9);
			if (r == 0) begin
				// Noise: coordinates anywhere in their range.
				for (k = 0; k < NUM_COORDS; k++)
					walk[k] = $urandom;
			end else if (r != 1) begin
				// Step one level forward and restart everything below it.
				lvl = $urandom_range(0, 1) ? nm_eff - 1 : $urandom_range(0, nm_eff - 1);
				walk[order[SEL_W*lvl +: SEL_W]] += $urandom_range(1, 3);
				for (k = lvl + 1; k < nm_eff; k++)
					walk[order[SEL_W*k +: SEL_W]] = $urandom_range(0, 2);
			end
			for (k = 0; k < NUM_COORDS; k++)
				data[COORD_W*k +: COORD_W] = walk[k];
			last = ($urandom_range(0, 11) == 0);
			offer_nonzero(data, last);
			build_fibers(data, last);
			foreach (step_entries[j])
				pending_entries.push_back(step_entries[j]);
		end
	endtask

	// Receiver: random stalls, one long hold-off on request, and the result check.
	initial begin
		int stall_left, hold_left;
		bit fire;
		fiber_entry_t got, want;
		stall_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 80;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready = 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
			#1;
			fire = (m_axis_tvalid === 1'b1) && m_axis_tready;
			got.level = m_axis_tdata[LEVEL_W-1:0];
			got.fiber_index = m_axis_tdata[LEVEL_W +: COORD_W];
			got.child_start = m_axis_tdata[LEVEL_W+COORD_W +: PTR_W];
			got.is_end = m_axis_tuser[0];
			got.run_last = m_axis_tlast;
			@(posedge clk);
			if (fire) begin
				if (pending_entries.size() == 0) begin
					$error("result with no expectation: level %0d fiber_index %0h child_start %0h",
						got.level, got.fiber_index, got.child_start);
					fail_count++;
				end else begin
					want = pending_entries.pop_front();
					if (got.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, got.level);
						fail_count++;
					end
					if (got.fiber_index !== want.fiber_index) begin
						$error("fiber_index: expected %0h, got %0h",
							want.fiber_index, got.fiber_index);
						fail_count++;
					end
					if (got.child_start !== want.child_start) begin
						$error("child_start: expected %0h, got %0h",
							want.child_start, got.child_start);
						fail_count++;
					end
					if (got.is_end !== want.is_end) begin
						$error("is_end: expected %0b, got %0b", want.is_end, got.is_end);
						fail_count++;
					end
					if (got.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
						fail_count++;
					end
				end
			end
		end
	end

	// Main sequence: reset, directed rows, then the random phases.
	initial begin
		logic [S_TDATA_W-1:0] data;
		logic [MODE_ORDER_W-1:0] order;
		int typed_pos, k;
		cfg_levels = NUM_MODES_RST;
		cfg_order = MODE_ORDER_RST;
		clear_fiber_state();
		for (k = 0; k < NUM_COORDS; k++)
			walk[k] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows run with the reset configuration: three identity-ordered levels.
		typed_pos = 0;
		foreach (dir_rows[i]) begin
			data[COORD_W*0 +: COORD_W] = dir_rows[i].c0;
			data[COORD_W*1 +: COORD_W] = dir_rows[i].c1;
			data[COORD_W*2 +: COORD_W] = dir_rows[i].c2;
			for (k = 3; k < NUM_COORDS; k++)
				data[COORD_W*k +: COORD_W] = dir_rows[i].c_rest;
			offer_nonzero(data, dir_rows[i].last);
			build_fibers(data, dir_rows[i].last);
			if (dir_rows[i].n_typed < 0) begin
				foreach (step_entries[j])
					pending_entries.push_back(step_entries[j]);
			end else begin
				for (k = 0; k < dir_rows[i].n_typed; k++)
					pending_entries.push_back(typed_tab[typed_pos + k]);
				typed_pos += dir_rows[i].n_typed;
			end
		end

		// Random phases; the second holds the receiver off, the fourth drains midway,
		// and the last runs with no idling at all.
		for (int p = 0; p < NUM_PHASES; p++) begin
			order = phase_rand_order[p] ? MODE_ORDER_W'($urandom) : phase_order[p];
			if (p == NUM_PHASES - 1) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			run_phase(phase_levels[p], order, 33, (p == 3) ? 16 : -1, p == 1);
		end

		settle_block();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("sparse_tensor_fiber_builder regression: pass");
		else
			$display("sparse_tensor_fiber_builder regression: fail");
		$finish;
	end

	// Watchdog against a stalled pipeline.
	initial begin
		#2000000;
		$display("sparse_tensor_fiber_builder regression: fail");
		$finish;
	end

endmodule

/* files.f */
design/fsf_pkg.sv
design/fsf_lane.sv
design/fsf_emit.sv
design/sparse_tensor_fiber_builder.sv
sim/sparse_tensor_fiber_builder_tb.sv
